/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the rectangle split checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define RSI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define RSI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/rsi_pkg.sv */
// ----------------------------------------------------------------------------
// rsi_pkg
// Types, constants and helpers for the rectangle split / intersection block.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int COORD_BITS = 16;
  localparam int POS_BITS   = COORD_BITS + 2;
  localparam int NUM_SIDES  = 4;

  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_LEFT   = 3'd1;
  localparam logic [2:0] KIND_RIGHT  = 3'd2;
  localparam logic [2:0] KIND_TOP    = 3'd3;
  localparam logic [2:0] KIND_BOTTOM = 3'd4;
  localparam logic [2:0] KIND_ISECT  = 3'd5;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-1:0] size_t;
  typedef logic signed [POS_BITS-1:0]   pos_t;

  typedef struct packed {
    coord_t base_x;
    coord_t base_y;
    size_t  base_width;
    size_t  base_height;
    coord_t other_x;
    coord_t other_y;
    size_t  other_width;
    size_t  other_height;
  } in_t;

  typedef struct packed {
    logic [2:0] piece_kind;
    coord_t     piece_x;
    coord_t     piece_y;
    size_t      piece_width;
    size_t      piece_height;
    logic       last_piece;
  } out_t;

  // Outside pieces in emit order, plus the closing result.
  typedef struct packed {
    logic [NUM_SIDES-1:0] mask;
    out_t                 left;
    out_t                 right;
    out_t                 top;
    out_t                 bottom;
    out_t                 isect;
  } piece_set_t;

  function automatic pos_t sext(input coord_t v);
    return {{(POS_BITS-COORD_BITS){v[COORD_BITS-1]}}, v};
  endfunction

  function automatic pos_t zext(input size_t v);
    return {{(POS_BITS-COORD_BITS){1'b0}}, v};
  endfunction

endpackage

/* rtl/rsi_geom.sv */
// ----------------------------------------------------------------------------
// rsi_geom
// Three-stage geometry pipeline: edge sums, edge compares, piece extents.
// ----------------------------------------------------------------------------
module rsi_geom (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rsi_pkg::in_t        in_data,
  output logic                set_valid,
  input  logic                set_stall,
  output rsi_pkg::piece_set_t set_data
);

  typedef struct packed {
    rsi_pkg::in_t item;
    rsi_pkg::pos_t br;
    rsi_pkg::pos_t bb;
    rsi_pkg::pos_t orr;
    rsi_pkg::pos_t ob;
  } s1_t;

  typedef struct packed {
    rsi_pkg::pos_t  bx;
    rsi_pkg::pos_t  by;
    rsi_pkg::pos_t  ox;
    rsi_pkg::pos_t  oy;
    rsi_pkg::pos_t  br;
    rsi_pkg::pos_t  bb;
    rsi_pkg::pos_t  orr;
    rsi_pkg::pos_t  ob;
    rsi_pkg::pos_t  ix;
    rsi_pkg::pos_t  iy;
    rsi_pkg::pos_t  re;
    rsi_pkg::pos_t  be;
    rsi_pkg::size_t oh;
    logic           f_left;
    logic           f_right;
    logic           f_top;
    logic           f_bottom;
    logic           hit;
  } s2_t;

  localparam int CB = rsi_pkg::COORD_BITS;

  logic                v1_r, v2_r, v3_r;
  logic                v1_nxt, v2_nxt, v3_nxt;
  logic                rdy1, rdy2, rdy3;
  s1_t                 s1_r, s1_nxt;
  s2_t                 s2_r, s2_nxt;
  rsi_pkg::piece_set_t s3_r, s3_nxt;

  assign rdy3     = !v3_r || !set_stall;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  assign v1_nxt = rdy1 ? in_valid : v1_r;
  assign v2_nxt = rdy2 ? v1_r : v2_r;
  assign v3_nxt = rdy3 ? v2_r : v3_r;

  // stage 1: far edges
  always_comb begin
    s1_nxt.item = in_data;
    s1_nxt.br   = rsi_pkg::sext(in_data.base_x) + rsi_pkg::zext(in_data.base_width);
    s1_nxt.bb   = rsi_pkg::sext(in_data.base_y) + rsi_pkg::zext(in_data.base_height);
    s1_nxt.orr  = rsi_pkg::sext(in_data.other_x) + rsi_pkg::zext(in_data.other_width);
    s1_nxt.ob   = rsi_pkg::sext(in_data.other_y) + rsi_pkg::zext(in_data.other_height);
  end

  // stage 2: compares, clipped edges
  always_comb begin
    s2_nxt.bx       = rsi_pkg::sext(s1_r.item.base_x);
    s2_nxt.by       = rsi_pkg::sext(s1_r.item.base_y);
    s2_nxt.ox       = rsi_pkg::sext(s1_r.item.other_x);
    s2_nxt.oy       = rsi_pkg::sext(s1_r.item.other_y);
    s2_nxt.br       = s1_r.br;
    s2_nxt.bb       = s1_r.bb;
    s2_nxt.orr      = s1_r.orr;
    s2_nxt.ob       = s1_r.ob;
    s2_nxt.oh       = s1_r.item.other_height;
    s2_nxt.f_left   = s2_nxt.ox < s2_nxt.bx;
    s2_nxt.f_right  = s1_r.orr > s1_r.br;
    s2_nxt.f_top    = s2_nxt.oy < s2_nxt.by;
    s2_nxt.f_bottom = s1_r.ob > s1_r.bb;
    s2_nxt.hit      = (s1_r.br > s2_nxt.ox) && (s1_r.bb > s2_nxt.oy) &&
                      (s2_nxt.bx < s1_r.orr) && (s2_nxt.by < s1_r.ob);
    s2_nxt.ix       = s2_nxt.f_left   ? s2_nxt.bx : s2_nxt.ox;
    s2_nxt.iy       = s2_nxt.f_top    ? s2_nxt.by : s2_nxt.oy;
    s2_nxt.re       = s2_nxt.f_right  ? s1_r.br   : s1_r.orr;
    s2_nxt.be       = s2_nxt.f_bottom ? s1_r.bb   : s1_r.ob;
  end

  // stage 3: extents and piece records
  always_comb begin
    rsi_pkg::pos_t d_lw, d_rw, d_th, d_hh, d_iw, d_ih;
    d_lw = s2_r.bx - s2_r.ox;
    d_rw = s2_r.orr - s2_r.br;
    d_th = s2_r.by - s2_r.oy;
    d_hh = s2_r.ob - s2_r.bb;
    d_iw = s2_r.re - s2_r.ix;
    d_ih = s2_r.be - s2_r.iy;

    s3_nxt.mask = {s2_r.f_bottom, s2_r.f_top, s2_r.f_right, s2_r.f_left}
                  & {rsi_pkg::NUM_SIDES{s2_r.hit}};

    s3_nxt.left.piece_kind   = rsi_pkg::KIND_LEFT;
    s3_nxt.left.piece_x      = s2_r.ox[CB-1:0];
    s3_nxt.left.piece_y      = s2_r.oy[CB-1:0];
    s3_nxt.left.piece_width  = d_lw[CB-1:0];
    s3_nxt.left.piece_height = s2_r.oh;
    s3_nxt.left.last_piece   = 1'b0;

    s3_nxt.right.piece_kind   = rsi_pkg::KIND_RIGHT;
    s3_nxt.right.piece_x      = s2_r.br[CB-1:0];
    s3_nxt.right.piece_y      = s2_r.oy[CB-1:0];
    s3_nxt.right.piece_width  = d_rw[CB-1:0];
    s3_nxt.right.piece_height = s2_r.oh;
    s3_nxt.right.last_piece   = 1'b0;

    s3_nxt.top.piece_kind   = rsi_pkg::KIND_TOP;
    s3_nxt.top.piece_x      = s2_r.ix[CB-1:0];
    s3_nxt.top.piece_y      = s2_r.oy[CB-1:0];
    s3_nxt.top.piece_width  = d_iw[CB-1:0];
    s3_nxt.top.piece_height = d_th[CB-1:0];
    s3_nxt.top.last_piece   = 1'b0;

    s3_nxt.bottom.piece_kind   = rsi_pkg::KIND_BOTTOM;
    s3_nxt.bottom.piece_x      = s2_r.ix[CB-1:0];
    s3_nxt.bottom.piece_y      = s2_r.bb[CB-1:0];
    s3_nxt.bottom.piece_width  = d_iw[CB-1:0];
    s3_nxt.bottom.piece_height = d_hh[CB-1:0];
    s3_nxt.bottom.last_piece   = 1'b0;

    s3_nxt.isect.last_piece = 1'b1;
    if (s2_r.hit) begin
      s3_nxt.isect.piece_kind   = rsi_pkg::KIND_ISECT;
      s3_nxt.isect.piece_x      = s2_r.ix[CB-1:0];
      s3_nxt.isect.piece_y      = s2_r.iy[CB-1:0];
      s3_nxt.isect.piece_width  = d_iw[CB-1:0];
      s3_nxt.isect.piece_height = d_ih[CB-1:0];
    end else begin
      s3_nxt.isect.piece_kind   = rsi_pkg::KIND_NONE;
      s3_nxt.isect.piece_x      = '0;
      s3_nxt.isect.piece_y      = '0;
      s3_nxt.isect.piece_width  = '0;
      s3_nxt.isect.piece_height = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_r <= s1_nxt;
    end
    if (rdy2 && v1_r) begin
      s2_r <= s2_nxt;
    end
    if (rdy3 && v2_r) begin
      s3_r <= s3_nxt;
    end
  end

  assign set_valid = v3_r;
  assign set_data  = s3_r;

endmodule

/* rtl/rsi_serial.sv */
// ----------------------------------------------------------------------------
// rsi_serial
// Holds one item's piece set and issues its results one per cycle into the
// output register while the output register is not stalled.
// ----------------------------------------------------------------------------
module rsi_serial (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                set_valid,
  output logic                set_stall,
  input  rsi_pkg::piece_set_t set_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rsi_pkg::out_t       out_data
);

  localparam int NP = rsi_pkg::NUM_SIDES + 1;

  logic [NP-1:0] pend_r, pend_nxt;
  logic [NP-1:0] sel_bit, pend_emit;
  logic          out_valid_r, out_valid_nxt;
  rsi_pkg::out_t out_data_r, out_data_nxt;
  rsi_pkg::out_t pieces_r [NP];
  rsi_pkg::out_t piece_sel;
  logic          out_take, set_load;

  assign out_take = !out_valid_r || !out_stall;

  // lowest pending piece goes first: left, right, top, bottom, closing
  always_comb begin
    sel_bit   = '0;
    piece_sel = pieces_r[NP-1];
    priority if (pend_r[0]) begin
      sel_bit[0] = 1'b1;
      piece_sel  = pieces_r[0];
    end else if (pend_r[1]) begin
      sel_bit[1] = 1'b1;
      piece_sel  = pieces_r[1];
    end else if (pend_r[2]) begin
      sel_bit[2] = 1'b1;
      piece_sel  = pieces_r[2];
    end else if (pend_r[3]) begin
      sel_bit[3] = 1'b1;
      piece_sel  = pieces_r[3];
    end else if (pend_r[4]) begin
      sel_bit[4] = 1'b1;
      piece_sel  = pieces_r[4];
    end else begin
      piece_sel = pieces_r[NP-1];
    end
  end

  assign pend_emit = out_take ? (pend_r & ~sel_bit) : pend_r;
  assign set_stall = (pend_emit != '0);
  assign set_load  = set_valid && (pend_emit == '0);
  assign pend_nxt  = set_load ? {1'b1, set_data.mask} : pend_emit;

  assign out_valid_nxt = out_take ? (pend_r != '0) : out_valid_r;
  assign out_data_nxt  = (out_take && (pend_r != '0)) ? piece_sel : out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (set_load) begin
      pieces_r[0] <= set_data.left;
      pieces_r[1] <= set_data.right;
      pieces_r[2] <= set_data.top;
      pieces_r[3] <= set_data.bottom;
      pieces_r[4] <= set_data.isect;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/rect_split_intersection_top.sv */
// An item's first result passes the geometry stages, the pending-piece register and the
// output register. Results leave one per cycle while out_stall is low; an item gives one
// result per outside piece plus the closing one, issued by the single output register.
// Geometry pipeline takes a new transaction every cycle while the issue stage has room.
// Reset (rst_n low, synchronous) empties every pipeline stage and the output register.
// ----------------------------------------------------------------------------
// rect_split_intersection_top
// Splits an other rectangle against a base into outside pieces and overlap.
// ----------------------------------------------------------------------------
module rect_split_intersection_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rsi_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output rsi_pkg::out_t out_data
);

  logic                set_valid;
  logic                set_stall;
  rsi_pkg::piece_set_t set_data;

  rsi_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .set_valid (set_valid),
    .set_stall (set_stall),
    .set_data  (set_data)
  );

  rsi_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .set_valid (set_valid),
    .set_stall (set_stall),
    .set_data  (set_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* rtl/rsi_checker.sv */
// ----------------------------------------------------------------------------
// rsi_checker
// Port-level checks for the rectangle split block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsi_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input rsi_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input rsi_pkg::out_t out_data
);

  `RSI_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "result dropped or changed while stalled")
  `RSI_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")
  `RSI_ASSERT(a_none_empty, clk, rst_n, out_valid && out_data.piece_kind == rsi_pkg::KIND_NONE |-> out_data.last_piece && out_data.piece_width == '0 && out_data.piece_height == '0 && out_data.piece_x == '0 && out_data.piece_y == '0, "no-overlap result not empty")
  `RSI_ASSERT(a_last_kind, clk, rst_n, out_valid |-> (out_data.last_piece == (out_data.piece_kind == rsi_pkg::KIND_NONE || out_data.piece_kind == rsi_pkg::KIND_ISECT)), "last flag does not match closing kind")
  `RSI_ASSERT(a_in_hold, clk, rst_n, in_valid && in_stall |=> $stable(in_data) || !in_valid, "input payload changed while stalled")

endmodule

bind rect_split_intersection_top rsi_checker u_rsi_checker (.*);

/* tb/rect_split_intersection_top_tb.sv */
// ----------------------------------------------------------------------------
// rect_split_intersection_top_tb
// Drives rectangle pairs into the splitter and checks every emitted piece
// (outside pieces, then the overlap, or one no-overlap result) against an
// in-bench predictor, partly under random idling on both channels.
// ----------------------------------------------------------------------------
module rect_split_intersection_top_tb;

  localparam int RX_HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES   = 8;
  localparam int STALL_LIMIT    = 2000;
  localparam int MAX_REPORTS    = 10;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  rsi_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  rsi_pkg::out_t out_data;

  rsi_pkg::out_t expected_pieces[$];
  int   mismatches = 0;
  int   idle_cycles = 0;
  bit   tx_idle_en = 1'b0;
  bit   rx_idle_en = 1'b0;
  bit   hold_req = 1'b0;

  rect_split_intersection_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin : clk_gen
    forever #4 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic rsi_pkg::out_t make_piece(logic [2:0] kind, longint x, longint y,
                                               longint w, longint h, logic last);
    rsi_pkg::out_t p;
    p.piece_kind   = kind;
    p.piece_x      = rsi_pkg::coord_t'(x);
    p.piece_y      = rsi_pkg::coord_t'(y);
    p.piece_width  = rsi_pkg::size_t'(w);
    p.piece_height = rsi_pkg::size_t'(h);
    p.last_piece   = last;
    return p;
  endfunction

  // Exact-width split of the other rectangle against the base.
  function automatic void split_rect(input rsi_pkg::in_t r);
    longint bx, by, bw, bh, ox, oy, ow, oh, ix, iy, iw, ih, d;
    bx = r.base_x;
    by = r.base_y;
    bw = r.base_width;
    bh = r.base_height;
    ox = r.other_x;
    oy = r.other_y;
    ow = r.other_width;
    oh = r.other_height;
    if (!(bx + bw > ox && by + bh > oy && bx < ox + ow && by < oy + oh)) begin
      expected_pieces.push_back(make_piece(rsi_pkg::KIND_NONE, 0, 0, 0, 0, 1'b1));
      return;
    end
    ix = ox;
    iy = oy;
    iw = ow;
    ih = oh;
    if (ix < bx) begin
      d = bx - ix;
      expected_pieces.push_back(make_piece(rsi_pkg::KIND_LEFT, ix, iy, d, ih, 1'b0));
      ix = bx;
      iw -= d;
    end
    if (ix + iw > bx + bw) begin
      d = iw - (bx + bw - ix);
      expected_pieces.push_back(make_piece(rsi_pkg::KIND_RIGHT, bx + bw, iy, d, ih, 1'b0));
      iw -= d;
    end
    if (iy < by) begin
      d = by - iy;
      expected_pieces.push_back(make_piece(rsi_pkg::KIND_TOP, ix, iy, iw, d, 1'b0));
      iy = by;
      ih -= d;
    end
    if (iy + ih > by + bh) begin
      d = ih - (by + bh - iy);
      expected_pieces.push_back(make_piece(rsi_pkg::KIND_BOTTOM, ix, by + bh, iw, d, 1'b0));
      ih -= d;
    end
    expected_pieces.push_back(make_piece(rsi_pkg::KIND_ISECT, ix, iy, iw, ih, 1'b1));
  endfunction

  function automatic rsi_pkg::in_t make_rects(int bx, int by, int bw, int bh,
                                              int ox, int oy, int ow, int oh);
    rsi_pkg::in_t r;
    r.base_x       = rsi_pkg::coord_t'(bx);
    r.base_y       = rsi_pkg::coord_t'(by);
    r.base_width   = rsi_pkg::size_t'(bw);
    r.base_height  = rsi_pkg::size_t'(bh);
    r.other_x      = rsi_pkg::coord_t'(ox);
    r.other_y      = rsi_pkg::coord_t'(oy);
    r.other_width  = rsi_pkg::size_t'(ow);
    r.other_height = rsi_pkg::size_t'(oh);
    return r;
  endfunction

  // Mostly nearby pairs so the split paths get exercised; some raw noise.
  function automatic rsi_pkg::in_t rand_rect_pair();
    rsi_pkg::in_t r;
    int           sel;
    r   = {$urandom, $urandom, $urandom, $urandom};
    sel = $urandom_range(0, 9);
    if (sel >= 2 && sel <= 7) begin
      r.base_width   = rsi_pkg::size_t'($urandom_range(0, 300));
      r.base_height  = rsi_pkg::size_t'($urandom_range(0, 300));
      r.other_width  = rsi_pkg::size_t'($urandom_range(0, 300));
      r.other_height = rsi_pkg::size_t'($urandom_range(0, 300));
      r.other_x      = rsi_pkg::coord_t'(int'(r.base_x) + int'($urandom_range(0, 600)) - 300);
      r.other_y      = rsi_pkg::coord_t'(int'(r.base_y) + int'($urandom_range(0, 600)) - 300);
    end else if (sel == 8) begin
      r.base_x       = rsi_pkg::coord_t'(int'($urandom_range(0, 40000)) - 32768);
      r.base_y       = rsi_pkg::coord_t'(int'($urandom_range(0, 40000)) - 32768);
      r.base_width   = rsi_pkg::size_t'($urandom_range(0, 30000));
      r.base_height  = rsi_pkg::size_t'($urandom_range(0, 30000));
      r.other_width  = rsi_pkg::size_t'($urandom_range(30000, 65535));
      r.other_height = rsi_pkg::size_t'($urandom_range(30000, 65535));
      r.other_x      = rsi_pkg::coord_t'(int'(r.base_x) - int'($urandom_range(0, 20000)));
      r.other_y      = rsi_pkg::coord_t'(int'(r.base_y) - int'($urandom_range(0, 20000)));
    end else if (sel == 9) begin
      r.base_x       = rsi_pkg::coord_t'(32767 - int'($urandom_range(0, 500)));
      r.base_y       = $urandom_range(0, 1)
                       ? rsi_pkg::coord_t'(32767 - int'($urandom_range(0, 500)))
                       : rsi_pkg::coord_t'(-32768 + int'($urandom_range(0, 500)));
      r.base_width   = rsi_pkg::size_t'($urandom_range(0, 2000));
      r.base_height  = rsi_pkg::size_t'($urandom_range(0, 2000));
      r.other_x      = rsi_pkg::coord_t'(int'(r.base_x) - int'($urandom_range(0, 800)));
      r.other_y      = rsi_pkg::coord_t'(int'(r.base_y) - int'($urandom_range(0, 800)));
      r.other_width  = rsi_pkg::size_t'($urandom_range(0, 4000));
      r.other_height = rsi_pkg::size_t'($urandom_range(0, 4000));
    end
    return r;
  endfunction

  task automatic send_rects(input rsi_pkg::in_t r);
    int gap;
    gap = 0;
    if (tx_idle_en && $urandom_range(0, 99) < 35) gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    split_rect(r);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_pieces.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed_shapes();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_rects(make_rects(0, 0, 10, 10, 100, 100, 5, 5));
    send_rects(make_rects(0, 0, 10, 10, 10, 0, 5, 5));
    send_rects(make_rects(0, 0, 10, 10, 0, 10, 5, 5));
    send_rects(make_rects(0, 0, 0, 0, 0, 0, 0, 0));
    send_rects(make_rects(0, 0, 100, 100, 10, 10, 20, 20));
    send_rects(make_rects(0, 0, 100, 100, -10, 10, 20, 20));
    send_rects(make_rects(0, 0, 100, 100, 90, 10, 20, 20));
    send_rects(make_rects(0, 0, 100, 100, 10, -10, 20, 20));
    send_rects(make_rects(0, 0, 100, 100, 10, 90, 20, 20));
    send_rects(make_rects(0, 0, 100, 100, -50, -50, 200, 200));
    send_rects(make_rects(50, 0, 0, 100, 0, 10, 100, 20));
    send_rects(make_rects(0, 50, 100, 0, 10, 0, 20, 100));
    send_rects(make_rects(0, 0, 100, 100, 50, 50, 0, 0));
    send_rects(make_rects(32000, 32000, 1000, 1000, 31000, 31000, 5000, 5000));
    send_rects(make_rects(-32768, -32768, 65535, 65535, -32768, -32768, 65535, 65535));
    send_rects(make_rects(-32768, -32768, 100, 100, -32768, -32768, 65535, 65535));
    send_rects(make_rects(-1, -1, 65535, 65535, -1, -1, 65535, 65535));
    send_rects(make_rects(32767, 32767, 65535, 65535, -32768, -32768, 65535, 65535));
    send_rects(make_rects(32766, 32766, 1, 1, -32768, -32768, 65535, 65535));
    send_rects(make_rects(-32768, 0, 65535, 10, 32767, 0, 65535, 10));
    send_rects(make_rects(32767, -32768, 65535, 65535, 32000, -32768, 2000, 65535));
    wait_drained();
  endtask

  task automatic test_random_full_rate();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (50) send_rects(rand_rect_pair());
    wait_drained();
  endtask

  task automatic test_random_idling();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (80) send_rects(rand_rect_pair());
    wait_drained();
  endtask

  task automatic test_output_hold();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_req   = 1'b1;
    repeat (30) send_rects(rand_rect_pair());
    wait_drained();
  endtask

  task automatic test_sender_pause();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (15) send_rects(rand_rect_pair());
    wait_drained();
    repeat (15) send_rects(rand_rect_pair());
    wait_drained();
  endtask

  initial begin : rx_stall_gen
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        for (n = 0; n < RX_HOLD_CYCLES; n++) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 99) < 30) begin
        out_stall <= 1'b1;
        repeat (gap_len()) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    rsi_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pieces.size() == 0) begin
        note_mismatch($sformatf("unexpected piece: kind %0d x %0d y %0d w %0d h %0d last %0d",
                                out_data.piece_kind, out_data.piece_x, out_data.piece_y,
                                out_data.piece_width, out_data.piece_height,
                                out_data.last_piece));
      end else begin
        want = expected_pieces.pop_front();
        if (out_data.piece_kind !== want.piece_kind || out_data.piece_x !== want.piece_x ||
            out_data.piece_y !== want.piece_y || out_data.piece_width !== want.piece_width ||
            out_data.piece_height !== want.piece_height ||
            out_data.last_piece !== want.last_piece) begin
          note_mismatch($sformatf({"piece mismatch: exp kind %0d x %0d y %0d w %0d h %0d ",
                                   "last %0d, got kind %0d x %0d y %0d w %0d h %0d last %0d"},
                                  want.piece_kind, want.piece_x, want.piece_y,
                                  want.piece_width, want.piece_height, want.last_piece,
                                  out_data.piece_kind, out_data.piece_x, out_data.piece_y,
                                  out_data.piece_width, out_data.piece_height,
                                  out_data.last_piece));
        end
      end
    end
  end

  // Watchdog: cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("no transaction for %0d cycles", STALL_LIMIT);
        $display("rect_split_intersection_top regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : main_seq
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_shapes();
    test_random_full_rate();
    test_random_idling();
    test_output_hold();
    test_sender_pause();
    if (mismatches == 0) begin
      $display("rect_split_intersection_top regression: pass");
    end else begin
      $display("rect_split_intersection_top regression: fail");
    end
    $finish;
  end

endmodule
